/* rtl/core/wpis_pkg.sv */
// shared types and constants of the probe frame information element scanner
// used by the queue, the parser, the top level and the checker
package wpis_pkg;

   // longest ssid length reported
   localparam logic [7:0] SSID_MAX_LEN = 8'd32;

   // configuration register indexes
   localparam logic CSR_VENDOR_ID  = 1'b0;
   localparam logic CSR_VENDOR_OUI = 1'b1;

   // configuration reset values
   localparam logic [7:0]  VENDOR_ID_RESET  = 8'd221;
   localparam logic [23:0] VENDOR_OUI_RESET = 24'h506F9A;

   // decoupling queue depth
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // result word layout, lowest bit first
   localparam int RSP_DATA_W = 16;

   // one body byte with its end of frame mark
   typedef struct packed {
      logic [7:0] body_byte;
      logic       last_byte;
   } item_type;

   // frame summary
   typedef struct packed {
      logic       vendor_ie_found;
      logic       ssid_wildcard;
      logic [5:0] ssid_length;
      logic       ssid_found;
   } summary_type;

   // handshake between queue and parser
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

/* rtl/core/wpis_queue.sv */
// front part: takes input beats and holds them in a short queue
// depends on wpis_pkg
module wpis_queue
   import wpis_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  item_type      push_item,
   output queue_out_type pop_out,
   input  logic          pop_ready
);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready    = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_out.valid = (count_ff != '0);
   assign pop_out.item  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_out.valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/wpis_parser.sv */
// back part: walks the tag-length-value elements and registers the summary
// depends on wpis_pkg
module wpis_parser
   import wpis_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type item_in,
   output logic          item_ready,
   input  logic          csr_write,
   input  logic          csr_index,
   input  logic [23:0]   csr_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output summary_type   rsp_summary
);

   typedef enum logic [1:0] {
      PH_ID  = 2'd0,
      PH_LEN = 2'd1,
      PH_VAL = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  element_id_ff, element_id_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [1:0]  offset_ff, offset_in;
   logic        oui_match_ff, oui_match_in;
   logic        ssid_resolved_ff, ssid_resolved_in;
   logic [7:0]  ssid_size_ff, ssid_size_in;
   logic        vendor_hit_ff, vendor_hit_in;
   logic [7:0]  vendor_id_ff;
   logic [23:0] vendor_oui_ff;
   logic        rsp_valid_ff;
   summary_type rsp_summary_ff, summary_in;
   logic        finish;
   logic [7:0]  want;
   logic [7:0]  clip_len;
   logic [7:0]  b;
   logic        pop;

   assign b          = item_in.item.body_byte;
   assign item_ready = !item_in.item.last_byte || !rsp_valid_ff || rsp_ready;
   assign pop        = item_in.valid && item_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_summary = rsp_summary_ff;

   // expected oui byte at the current value offset
   always_comb begin
      case (offset_ff)
         2'd0:    want = vendor_oui_ff[23:16];
         2'd1:    want = vendor_oui_ff[15:8];
         default: want = vendor_oui_ff[7:0];
      endcase
   end

   // element walk for one byte
   always_comb begin
      phase_in         = phase_ff;
      element_id_in    = element_id_ff;
      bytes_left_in    = bytes_left_ff;
      offset_in        = offset_ff;
      oui_match_in     = oui_match_ff;
      ssid_resolved_in = ssid_resolved_ff;
      ssid_size_in     = ssid_size_ff;
      vendor_hit_in    = vendor_hit_ff;
      finish           = 1'b0;
      case (phase_ff)
         PH_LEN: begin
            bytes_left_in = b;
            offset_in     = 2'd0;
            if (element_id_ff == 8'd0 && !ssid_resolved_ff) begin
               ssid_size_in = b;
            end
            oui_match_in = (element_id_ff == vendor_id_ff) && (b >= 8'd4);
            if (b == 8'd0) begin
               finish = 1'b1;
            end else begin
               phase_in = PH_VAL;
            end
         end
         PH_VAL: begin
            if (offset_ff != 2'd3) begin
               if (b != want) begin
                  oui_match_in = 1'b0;
               end
               offset_in = offset_ff + 2'd1;
            end
            bytes_left_in = bytes_left_ff - 8'd1;
            if (bytes_left_in == 8'd0) begin
               finish = 1'b1;
            end
         end
         default: begin
            element_id_in = b;
            phase_in      = PH_LEN;
         end
      endcase

      // element complete
      if (finish) begin
         if (element_id_ff == 8'd0) begin
            ssid_resolved_in = 1'b1;
         end
         if (oui_match_in) begin
            vendor_hit_in = 1'b1;
         end
         oui_match_in = 1'b0;
         phase_in     = PH_ID;
      end

      // frame summary
      clip_len = (ssid_size_in > SSID_MAX_LEN) ? SSID_MAX_LEN : ssid_size_in;
      summary_in.ssid_found      = ssid_resolved_in;
      summary_in.ssid_length     = ssid_resolved_in ? clip_len[5:0] : 6'd0;
      summary_in.ssid_wildcard   = ssid_resolved_in && (ssid_size_in == 8'd0);
      summary_in.vendor_ie_found = vendor_hit_in;

      // frame end clears the walk
      if (item_in.item.last_byte) begin
         phase_in         = PH_ID;
         element_id_in    = 8'd0;
         bytes_left_in    = 8'd0;
         offset_in        = 2'd0;
         oui_match_in     = 1'b0;
         ssid_resolved_in = 1'b0;
         ssid_size_in     = 8'd0;
         vendor_hit_in    = 1'b0;
      end
   end

   // walk state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_ID;
         element_id_ff    <= 8'd0;
         bytes_left_ff    <= 8'd0;
         offset_ff        <= 2'd0;
         oui_match_ff     <= 1'b0;
         ssid_resolved_ff <= 1'b0;
         ssid_size_ff     <= 8'd0;
         vendor_hit_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff         <= phase_in;
            element_id_ff    <= element_id_in;
            bytes_left_ff    <= bytes_left_in;
            offset_ff        <= offset_in;
            oui_match_ff     <= oui_match_in;
            ssid_resolved_ff <= ssid_resolved_in;
            ssid_size_ff     <= ssid_size_in;
            vendor_hit_ff    <= vendor_hit_in;
         end
         if (pop && item_in.item.last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // summary payload
   always_ff @(posedge clock) begin
      if (pop && item_in.item.last_byte) begin
         rsp_summary_ff <= summary_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vendor_id_ff  <= VENDOR_ID_RESET;
         vendor_oui_ff <= VENDOR_OUI_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_VENDOR_ID:  vendor_id_ff  <= csr_data[7:0];
            CSR_VENDOR_OUI: vendor_oui_ff <= csr_data;
            default:        vendor_id_ff  <= vendor_id_ff;
         endcase
      end
   end

endmodule

/* rtl/core/wifi_probe_ie_scanner_core.sv */
// top level of the probe frame information element scanner
// depends on wpis_pkg, wpis_queue and wpis_parser
//
// usage:
//   req_* carries the management frame body, one byte per beat, with
//   req_tlast high on the final body byte. rsp_* carries one summary beat
//   per frame, sent after the beat that had req_tlast set.
//   csr_* writes the vendor element id (index 0) and the vendor oui
//   (index 1, first oui byte in bits 23:16); csr_ready is always high.
//   write configuration only while no frame is in flight.
// throughput: one body byte per cycle unless the summary output stalls, set
//   by the parser's element walk; a four-entry queue sits between intake and parser.
// path: with an empty queue, the last accepted byte passes the queue slot
//   register and then the output register before its summary appears on rsp_*.
// reset: synchronous; empties the queue, clears the frame state and loads
//   the default vendor id 221 and oui 50:6f:9a.
// stall: while rsp_tready is low the summary holds; body bytes keep
//   flowing until the queue fills or a second last byte reaches the parser.
module wifi_probe_ie_scanner_core
   import wpis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // body_byte
   input  logic                  req_tlast,  // last_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // ssid_found [0], ssid_length [6:1], ssid_wildcard [7],
   // vendor_ie_found [8], zero [15:9]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [23:0]           csr_data
);

   item_type      push_item;
   queue_out_type queue_out;
   logic          parser_ready;
   summary_type   summary;

   assign push_item.body_byte = req_tdata;
   assign push_item.last_byte = req_tlast;
   assign csr_ready           = 1'b1;
   assign rsp_tdata           = {7'd0, summary};

   // intake queue
   wpis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (push_item),
      .pop_out    (queue_out),
      .pop_ready  (parser_ready)
   );

   // element walk and summary
   wpis_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_in     (queue_out),
      .item_ready  (parser_ready),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_summary (summary)
   );

endmodule

/* rtl/core/wpis_checker.sv */
// port-level checks on the scanner summary channel
// depends on wpis_pkg; bound to wifi_probe_ie_scanner_core
module wpis_checker
   import wpis_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled summary beat stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("summary beat dropped while stalled");

   // no ssid means zero length and no wildcard
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[7:1] == 7'd0)
      else $error("ssid fields set without ssid");

   // wildcard only with a found ssid of zero length
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tdata[0] && rsp_tdata[6:1] == 6'd0)
      else $error("wildcard inconsistent with length");

   // length never above the clip and padding is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({2'b00, rsp_tdata[6:1]} <= SSID_MAX_LEN)
                     && rsp_tdata[15:9] == 7'd0)
      else $error("summary length or padding out of range");

endmodule

bind wifi_probe_ie_scanner_core wpis_checker u_wpis_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/tb_top.sv */
// self-checking bench for the probe frame information element scanner
// drives body bytes and csr writes, predicts random frame summaries, checks rsp beats
// depends on wpis_pkg and wifi_probe_ie_scanner_core
module tb_top
   import wpis_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BYTES  = 275;
   localparam int PHASE_COUNT  = 6;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT_BEAT = 25;

   // element walk of the predictor
   typedef enum logic [1:0] {
      WAIT_ID  = 2'd0,
      WAIT_LEN = 2'd1,
      IN_VALUE = 2'd2
   } walk_phase_type;

   // one row of the directed table
   typedef struct packed {
      logic [7:0]  body;
      logic        last;
      logic        typed;
      summary_type want;
   } stim_row_type;

   // hand-written summaries: vendor_ie_found, ssid_wildcard, ssid_length, ssid_found
   localparam summary_type NOTHING_FOUND = '0;
   localparam summary_type WILDCARD_SSID = '{1'b0, 1'b1, 6'd0, 1'b1};
   localparam summary_type VENDOR_ONLY   = '{1'b1, 1'b0, 6'd0, 1'b0};
   localparam summary_type ONE_BYTE_SSID = '{1'b0, 1'b0, 6'd1, 1'b1};

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = CSR_VENDOR_ID;
   logic [23:0]           csr_data = '0;

   // predictor state and register copies
   walk_phase_type walk_phase = WAIT_ID;
   logic [7:0]  cur_id = '0;
   logic [7:0]  remaining = '0;
   logic [1:0]  value_pos = '0;
   logic        oui_ok = 1'b0;
   logic        ssid_done = 1'b0;
   logic [7:0]  held_size = '0;
   logic        vend_seen = 1'b0;
   logic [7:0]  cfg_vendor_id = VENDOR_ID_RESET;
   logic [23:0] cfg_oui = VENDOR_OUI_RESET;

   summary_type  pending_summaries[$];
   logic [7:0]   frame_bytes[$];
   stim_row_type directed_rows[24];
   int           bytes_sent = 0;
   int           summaries_seen = 0;
   int           fail_count = 0;
   int           cycle_count = 0;

   wifi_probe_ie_scanner_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // all bytes of the current element are in
   task automatic close_element();
      if (cur_id == 8'd0 && !ssid_done)
         ssid_done = 1'b1;
      if (oui_ok)
         vend_seen = 1'b1;
      oui_ok = 1'b0;
      walk_phase = WAIT_ID;
   endtask

   // advance the element walk by one body byte; gives the summary on the last byte
   task automatic scan_byte(input logic [7:0] b, input logic last,
                            output logic has_sum, output summary_type sum);
      logic [7:0] want;
      logic [7:0] clipped;
      has_sum = 1'b0;
      sum = '0;
      case (walk_phase)
         WAIT_LEN: begin
            remaining = b;
            value_pos = '0;
            if (cur_id == 8'd0 && !ssid_done)
               held_size = b;
            oui_ok = (cur_id == cfg_vendor_id) && (b >= 8'd4);
            if (b == 8'd0)
               close_element();
            else
               walk_phase = IN_VALUE;
         end
         IN_VALUE: begin
            if (value_pos != 2'd3) begin
               case (value_pos)
                  2'd0:    want = cfg_oui[23:16];
                  2'd1:    want = cfg_oui[15:8];
                  default: want = cfg_oui[7:0];
               endcase
               if (b != want)
                  oui_ok = 1'b0;
               value_pos = value_pos + 2'd1;
            end
            remaining = remaining - 8'd1;
            if (remaining == 8'd0)
               close_element();
         end
         default: begin
            cur_id = b;
            walk_phase = WAIT_LEN;
         end
      endcase
      if (last) begin
         clipped = (held_size > SSID_MAX_LEN) ? SSID_MAX_LEN : held_size;
         has_sum = 1'b1;
         sum.ssid_found = ssid_done;
         sum.ssid_length = ssid_done ? clipped[5:0] : 6'd0;
         sum.ssid_wildcard = ssid_done && (held_size == 8'd0);
         sum.vendor_ie_found = vend_seen;
         // frame state back to reset
         walk_phase = WAIT_ID;
         cur_id = '0;
         remaining = '0;
         value_pos = '0;
         oui_ok = 1'b0;
         ssid_done = 1'b0;
         held_size = '0;
         vend_seen = 1'b0;
      end
   endtask

   // offer one body byte after a gap and predict once it is taken
   task automatic send_body_byte(input logic [7:0] b, input logic last, input int gap,
                                 input logic typed, input summary_type typed_sum);
      logic        has_sum;
      summary_type sum;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      scan_byte(b, last, has_sum, sum);
      if (has_sum)
         pending_summaries.push_back(typed ? typed_sum : sum);
   endtask

   // csr write beat; the caller drops csr_valid after the last write
   task automatic write_csr(input logic idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_VENDOR_ID)
         cfg_vendor_id = val[7:0];
      else
         cfg_oui = val;
   endtask

   // stop offering and let every frame summary drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // random frame: mostly element sequences, some cut short, some noise
   task automatic build_frame();
      int kind;
      int n_elem;
      int etype;
      int len;
      int bad_pos;
      logic [7:0] v;
      frame_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         n_elem = $urandom_range(1, 20);
         repeat (n_elem) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         n_elem = $urandom_range(1, 4);
         repeat (n_elem) begin
            etype = $urandom_range(0, 3);
            bad_pos = -1;
            case (etype)
               0: begin
                  // ssid, sometimes empty or longer than the clip
                  frame_bytes.push_back(8'd0);
                  case ($urandom_range(0, 19))
                     0:       len = 0;
                     1:       len = $urandom_range(33, 255);
                     default: len = $urandom_range(1, 32);
                  endcase
               end
               1, 3: begin
                  // vendor element, with a bad oui byte now and then
                  frame_bytes.push_back(cfg_vendor_id);
                  len = (etype == 1) ? $urandom_range(3, 8) : $urandom_range(0, 3);
                  if ($urandom_range(0, 3) == 0)
                     bad_pos = $urandom_range(0, 2);
               end
               default: begin
                  frame_bytes.push_back(8'($urandom_range(0, 255)));
                  len = ($urandom_range(0, 29) == 0) ? $urandom_range(64, 255)
                                                     : $urandom_range(0, 6);
               end
            endcase
            frame_bytes.push_back(8'(len));
            for (int i = 0; i < len; i++) begin
               if ((etype == 1 || etype == 3) && i < 3)
                  v = cfg_oui[23 - 8*i -: 8];
               else
                  v = 8'($urandom_range(0, 255));
               if (i == bad_pos)
                  v = v ^ 8'($urandom_range(1, 255));
               frame_bytes.push_back(v);
            end
         end
         // truncate or add trailing noise
         if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
         end else if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // result side: random stalls, one long hold-off, field compare
   initial begin
      int stall;
      int no_stall;
      summary_type got;
      summary_type want;
      no_stall = 0;
      @(negedge reset);
      forever begin
         if (summaries_seen % 16 == 0)
            no_stall = ($urandom_range(0, 2) == 0);
         stall = no_stall ? 0 : $urandom_range(0, 8);
         if (summaries_seen == HOLD_AT_BEAT)
            stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = summary_type'(rsp_tdata[8:0]);
         summaries_seen++;
         if (pending_summaries.size() == 0) begin
            $error("summary beat with nothing pending: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_summaries.pop_front();
            if (got.ssid_found !== want.ssid_found) begin
               $error("ssid_found: expected %0d, got %0d", want.ssid_found, got.ssid_found);
               fail_count++;
            end
            if (got.ssid_length !== want.ssid_length) begin
               $error("ssid_length: expected %0d, got %0d",
                      want.ssid_length, got.ssid_length);
               fail_count++;
            end
            if (got.ssid_wildcard !== want.ssid_wildcard) begin
               $error("ssid_wildcard: expected %0d, got %0d",
                      want.ssid_wildcard, got.ssid_wildcard);
               fail_count++;
            end
            if (got.vendor_ie_found !== want.vendor_ie_found) begin
               $error("vendor_ie_found: expected %0d, got %0d",
                      want.vendor_ie_found, got.vendor_ie_found);
               fail_count++;
            end
         end
      end
   end

   // stimulus: reset, directed frames, then random frames per register setting
   initial begin
      logic [7:0]  phase_ids[PHASE_COUNT];
      logic [23:0] phase_ouis[PHASE_COUNT];
      int          target;
      int          burst;
      int          gap;

      // single id byte, empty ssid, default vendor hit, repeated ssid,
      // vendor too short, vendor cut off by the frame end
      directed_rows = '{
         '{8'hFF, 1'b1, 1'b1, NOTHING_FOUND},
         '{8'h00, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h00, 1'b1, 1'b1, WILDCARD_SSID},
         '{8'd221, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h04, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h50, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h6F, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h9A, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h01, 1'b1, 1'b1, VENDOR_ONLY},
         '{8'h00, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h01, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'hFF, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h00, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h00, 1'b1, 1'b1, ONE_BYTE_SSID},
         '{8'd221, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h03, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h50, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h6F, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h9A, 1'b1, 1'b1, NOTHING_FOUND},
         '{8'd221, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h05, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h50, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h6F, 1'b0, 1'b0, NOTHING_FOUND},
         '{8'h9A, 1'b1, 1'b1, NOTHING_FOUND}
      };

      // register settings: reset values, both extremes, random, defaults again, random
      phase_ids[0] = VENDOR_ID_RESET;
      phase_ouis[0] = VENDOR_OUI_RESET;
      phase_ids[1] = 8'd0;
      phase_ouis[1] = 24'h000000;
      phase_ids[2] = 8'hFF;
      phase_ouis[2] = 24'hFFFFFF;
      phase_ids[3] = 8'($urandom_range(0, 255));
      phase_ouis[3] = 24'($urandom_range(0, 24'hFFFFFF));
      phase_ids[4] = VENDOR_ID_RESET;
      phase_ouis[4] = VENDOR_OUI_RESET;
      phase_ids[5] = 8'($urandom_range(0, 255));
      phase_ouis[5] = 24'($urandom_range(0, 24'hFFFFFF));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_body_byte(directed_rows[i].body, directed_rows[i].last,
                        $urandom_range(0, 8), directed_rows[i].typed,
                        directed_rows[i].want);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         if (p > 0) begin
            write_csr(CSR_VENDOR_ID, {16'd0, phase_ids[p]});
            write_csr(CSR_VENDOR_OUI, phase_ouis[p]);
            csr_valid <= 1'b0;
            @(posedge clock);
         end
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            build_frame();
            burst = ($urandom_range(0, 3) == 0);
            foreach (frame_bytes[i]) begin
               gap = burst ? 0 : $urandom_range(0, 8);
               send_body_byte(frame_bytes[i], i == frame_bytes.size() - 1, gap,
                              1'b0, NOTHING_FOUND);
            end
         end
      end

      // drain, then allow the output latency
      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/wpis_pkg.sv
rtl/core/wpis_queue.sv
rtl/core/wpis_parser.sv
rtl/core/wifi_probe_ie_scanner_core.sv
rtl/core/wpis_checker.sv
bench/tb_top.sv
